@@ rtl/slb_pkg.sv @@
package slb_pkg;

  localparam int TIME_BITS       = 32;
  localparam int INT_FAST        = 1000 / 2 / 2;
  localparam int INT_MID         = 1000 / 2;
  localparam int INT_SLOW        = 1000 * 2;
  localparam int PWM_ONE_PERCENT = (65535 / 100) + 1;
  localparam int PWM_THRESHOLD   = PWM_ONE_PERCENT / 2;
  localparam int FULL_LEVEL      = 255;
  localparam int QDEPTH          = 4;

  localparam int FW = $clog2(INT_FAST);
  localparam int MW = $clog2(INT_MID);
  localparam int SW = $clog2(INT_SLOW);

  // slow interval = ALIGN_BASE << ALIGN_LOW_BITS; floor(x / ALIGN_BASE) by reciprocal multiply
  localparam int     ALIGN_LOW_BITS = 4;
  localparam int     ALIGN_BASE     = INT_SLOW >> ALIGN_LOW_BITS;
  localparam int     ALIGN_QW       = TIME_BITS - ALIGN_LOW_BITS;
  localparam int     ALIGN_SHIFT    = ALIGN_QW + $clog2(ALIGN_BASE);
  localparam longint ALIGN_MAGIC    = ((longint'(1) << ALIGN_SHIFT) + longint'(ALIGN_BASE) - 1)
                                      / longint'(ALIGN_BASE);
  localparam int     MAGIC_W        = $clog2(ALIGN_MAGIC + 1);

  typedef enum logic [1:0] {
    MODE_ON      = 2'd0,
    MODE_HEATER  = 2'd1,
    MODE_ALERTS  = 2'd2,
    MODE_INVALID = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CMD_OFF   = 3'd0,
    CMD_RED   = 3'd1,
    CMD_GREEN = 3'd2,
    CMD_BLUE  = 3'd3,
    CMD_WHITE = 3'd4
  } led_cmd_t;

  typedef struct packed {
    logic     two;
    led_cmd_t cmd0;
    led_cmd_t cmd1;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic          done;
    logic [FW-1:0] rem_fast;
    logic [MW-1:0] rem_mid;
    logic [SW-1:0] rem_slow;
  } align_res_t;

  typedef struct packed {
    logic       lit;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } led_rgb_t;

  function automatic led_rgb_t cmd_to_rgb(led_cmd_t c);
    led_rgb_t v;
    v = '0;
    case (c)
      CMD_RED: begin
        v.lit = 1'b1;
        v.r   = 8'(FULL_LEVEL);
      end
      CMD_GREEN: begin
        v.lit = 1'b1;
        v.g   = 8'(FULL_LEVEL);
      end
      CMD_BLUE: begin
        v.lit = 1'b1;
        v.b   = 8'(FULL_LEVEL);
      end
      CMD_WHITE: begin
        v.lit = 1'b1;
        v.r   = 8'(FULL_LEVEL);
        v.g   = 8'(FULL_LEVEL);
        v.b   = 8'(FULL_LEVEL);
      end
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/slb_align.sv @@
module slb_align import slb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [TIME_BITS-1:0] now,
  output align_res_t           res
);

  localparam int PRW = ALIGN_QW + MAGIC_W;

  logic                      st1_r, st2_r, done_r;
  logic [ALIGN_QW-1:0]       x_r;
  logic [ALIGN_QW-1:0]       q_r, q_nxt;
  logic [ALIGN_LOW_BITS-1:0] lo_r;
  logic [SW-1:0]             rs_r, rs_nxt;
  logic [MW-1:0]             rm_r, rm_nxt;
  logic [FW-1:0]             rf_r, rf_nxt;
  logic [PRW-1:0]            prod;
  logic [ALIGN_QW-1:0]       rem_base;

  assign prod     = PRW'(now[TIME_BITS-1:ALIGN_LOW_BITS]) * PRW'(ALIGN_MAGIC);
  assign q_nxt    = ALIGN_QW'(prod >> ALIGN_SHIFT);
  assign rem_base = x_r - ALIGN_QW'(q_r * ALIGN_QW'(ALIGN_BASE));
  assign rs_nxt   = SW'({rem_base, lo_r});

  always_comb begin
    if (rs_r >= SW'(3 * INT_MID)) begin
      rm_nxt = MW'(rs_r - SW'(3 * INT_MID));
    end else if (rs_r >= SW'(2 * INT_MID)) begin
      rm_nxt = MW'(rs_r - SW'(2 * INT_MID));
    end else if (rs_r >= SW'(INT_MID)) begin
      rm_nxt = MW'(rs_r - SW'(INT_MID));
    end else begin
      rm_nxt = MW'(rs_r);
    end
    if (rm_nxt >= MW'(INT_FAST)) begin
      rf_nxt = FW'(rm_nxt - MW'(INT_FAST));
    end else begin
      rf_nxt = FW'(rm_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_r  <= 1'b0;
      st2_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      st1_r  <= start;
      st2_r  <= st1_r;
      done_r <= st2_r;
    end
    if (start) begin
      x_r  <= now[TIME_BITS-1:ALIGN_LOW_BITS];
      q_r  <= q_nxt;
      lo_r <= now[ALIGN_LOW_BITS-1:0];
    end
    if (st1_r) begin
      rs_r <= rs_nxt;
    end
    if (st2_r) begin
      rm_r <= rm_nxt;
      rf_r <= rf_nxt;
    end
  end

  assign res.done     = done_r;
  assign res.rem_fast = rf_r;
  assign res.rem_mid  = rm_r;
  assign res.rem_slow = rs_r;

endmodule

@@ rtl/slb_front.sv @@
module slb_front import slb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          in_now_ms,
  input  logic                 in_halt_error,
  input  logic                 in_screen_present,
  input  logic                 in_readings_valid,
  input  logic                 in_alerts_pending,
  input  logic [15:0]          in_heater_pwm,
  output logic                 align_start,
  output logic [TIME_BITS-1:0] align_now,
  input  align_res_t           align_res,
  input  q_stat_t              q_stat,
  output logic                 push,
  output q_entry_t             push_data
);

  typedef enum logic [2:0] {
    ST_FIRST = 3'b001,
    ST_ALIGN = 3'b010,
    ST_RUN   = 3'b100
  } fst_t;

  fst_t                 state_r, state_nxt;
  logic [TIME_BITS-1:0] mk_fast_r, mk_fast_nxt;
  logic [TIME_BITS-1:0] mk_mid_r, mk_mid_nxt;
  logic [TIME_BITS-1:0] mk_slow_r, mk_slow_nxt;
  logic                 ph_fast_r, ph_fast_nxt;
  logic                 ph_mid_r, ph_mid_nxt;
  logic                 ph_slow_r, ph_slow_nxt;
  mode_t                prev_mode_r, prev_mode_nxt;

  logic [TIME_BITS-1:0] now_t;
  logic                 due_f, due_m, due_s;
  logic                 sv;
  mode_t                mode;
  logic                 ent, edge_emit;
  led_cmd_t             ent_cmd, edge_cmd;

  assign now_t     = TIME_BITS'(in_now_ms);
  assign align_now = now_t;
  assign due_f     = TIME_BITS'(now_t - mk_fast_r) >= TIME_BITS'(INT_FAST);
  assign due_m     = TIME_BITS'(now_t - mk_mid_r)  >= TIME_BITS'(INT_MID);
  assign due_s     = TIME_BITS'(now_t - mk_slow_r) >= TIME_BITS'(INT_SLOW);
  assign sv        = in_screen_present & in_readings_valid;

  always_comb begin
    if (!sv) begin
      mode = MODE_INVALID;
    end else if (in_alerts_pending) begin
      mode = MODE_ALERTS;
    end else if (in_heater_pwm >= 16'(PWM_THRESHOLD)) begin
      mode = MODE_HEATER;
    end else begin
      mode = MODE_ON;
    end
  end

  always_comb begin
    ent       = 1'b0;
    ent_cmd   = CMD_OFF;
    edge_emit = 1'b0;
    edge_cmd  = CMD_OFF;
    case (mode)
      MODE_ALERTS: begin
        ent       = (prev_mode_r != MODE_ALERTS);
        ent_cmd   = CMD_RED;
        edge_emit = due_m;
        edge_cmd  = ph_mid_r ? CMD_OFF : CMD_RED;
      end
      MODE_HEATER: begin
        ent       = (prev_mode_r != MODE_HEATER);
        ent_cmd   = CMD_BLUE;
        edge_emit = due_s;
        edge_cmd  = ph_slow_r ? CMD_OFF : CMD_BLUE;
      end
      MODE_ON: begin
        ent     = 1'b1;
        ent_cmd = CMD_GREEN;
      end
      default: begin
        ent     = 1'b1;
        ent_cmd = CMD_WHITE;
      end
    endcase
  end

  assign in_ready = (state_r == ST_RUN) && !q_stat.full;

  always_comb begin
    state_nxt     = state_r;
    mk_fast_nxt   = mk_fast_r;
    mk_mid_nxt    = mk_mid_r;
    mk_slow_nxt   = mk_slow_r;
    ph_fast_nxt   = ph_fast_r;
    ph_mid_nxt    = ph_mid_r;
    ph_slow_nxt   = ph_slow_r;
    prev_mode_nxt = prev_mode_r;
    align_start   = 1'b0;
    push          = 1'b0;
    push_data     = '0;
    case (state_r)
      ST_FIRST: begin
        if (in_valid) begin
          align_start = 1'b1;
          state_nxt   = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        if (align_res.done) begin
          mk_fast_nxt = now_t - TIME_BITS'(align_res.rem_fast);
          mk_mid_nxt  = now_t - TIME_BITS'(align_res.rem_mid);
          mk_slow_nxt = now_t - TIME_BITS'(align_res.rem_slow);
          ph_fast_nxt = 1'b0;
          ph_mid_nxt  = 1'b0;
          ph_slow_nxt = 1'b0;
          state_nxt   = ST_RUN;
        end
      end
      ST_RUN: begin
        if (in_valid && in_ready) begin
          if (due_f) begin
            mk_fast_nxt = mk_fast_r + TIME_BITS'(INT_FAST);
          end
          if (due_f && in_halt_error) begin
            push           = 1'b1;
            push_data.two  = 1'b0;
            push_data.cmd0 = ph_fast_r ? CMD_OFF : CMD_RED;
            push_data.cmd1 = CMD_OFF;
            ph_fast_nxt    = !ph_fast_r;
          end else begin
            if (sv) begin
              prev_mode_nxt = mode;
            end
            if (due_m) begin
              mk_mid_nxt = mk_mid_r + TIME_BITS'(INT_MID);
              if (mode == MODE_ALERTS) begin
                ph_mid_nxt = !ph_mid_r;
              end
            end
            if (due_s) begin
              mk_slow_nxt = mk_slow_r + TIME_BITS'(INT_SLOW);
              if (mode == MODE_HEATER) begin
                ph_slow_nxt = !ph_slow_r;
              end
            end
            push           = ent | edge_emit;
            push_data.two  = ent & edge_emit;
            push_data.cmd0 = ent ? ent_cmd : edge_cmd;
            push_data.cmd1 = edge_cmd;
          end
        end
      end
      default: state_nxt = ST_FIRST;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FIRST;
      mk_fast_r   <= '0;
      mk_mid_r    <= '0;
      mk_slow_r   <= '0;
      ph_fast_r   <= 1'b0;
      ph_mid_r    <= 1'b0;
      ph_slow_r   <= 1'b0;
      prev_mode_r <= MODE_INVALID;
    end else begin
      state_r     <= state_nxt;
      mk_fast_r   <= mk_fast_nxt;
      mk_mid_r    <= mk_mid_nxt;
      mk_slow_r   <= mk_slow_nxt;
      ph_fast_r   <= ph_fast_nxt;
      ph_mid_r    <= ph_mid_nxt;
      ph_slow_r   <= ph_slow_nxt;
      prev_mode_r <= prev_mode_nxt;
    end
  end

endmodule

@@ rtl/slb_queue.sv @@
module slb_queue import slb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_data,
  input  logic     pop,
  output q_entry_t head,
  output q_stat_t  stat
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  q_entry_t      mem_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == CW'(QDEPTH));
  assign stat.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/slb_back.sv @@
module slb_back import slb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  q_entry_t   head,
  input  q_stat_t   q_stat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_led_lit,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic       out_last
);

  logic     valid_r, valid_nxt;
  logic     sub_r, sub_nxt;
  led_rgb_t rgb_r, rgb_nxt;
  logic     last_r, last_nxt;
  logic     load;
  logic     is_last;
  led_cmd_t cmd;

  assign load    = !q_stat.empty && (!valid_r || out_ready);
  assign is_last = !head.two || sub_r;
  assign cmd     = sub_r ? head.cmd1 : head.cmd0;
  assign pop     = load && is_last;

  always_comb begin
    valid_nxt = valid_r;
    sub_nxt   = sub_r;
    rgb_nxt   = rgb_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = 1'b1;
      sub_nxt   = !is_last;
      rgb_nxt   = cmd_to_rgb(cmd);
      last_nxt  = is_last;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sub_r   <= sub_nxt;
    end
    rgb_r  <= rgb_nxt;
    last_r <= last_nxt;
  end

  assign out_valid   = valid_r;
  assign out_led_lit = rgb_r.lit;
  assign out_red     = rgb_r.r;
  assign out_green   = rgb_r.g;
  assign out_blue    = rgb_r.b;
  assign out_last    = last_r;

endmodule

@@ rtl/status_led_blink_controller_unit.sv @@
// Path: an accepted tick is written into the command queue, and the back end then loads its
// first LED command into the output register once that register is free.
// Throughput: one tick per cycle while the command queue is not full; the output register
// moves one LED command per cycle while out_ready is high, so a tick that gives two commands
// holds the result side for both of them. The first tick after reset is held while a
// three-stage reciprocal-multiply remainder unit aligns the three blink markers.
// Reset: synchronous, active low; clears markers, phases and queue, prev mode to invalid.
module status_led_blink_controller_unit import slb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_now_ms,
  input  logic        in_halt_error,
  input  logic        in_screen_present,
  input  logic        in_readings_valid,
  input  logic        in_alerts_pending,
  input  logic [15:0] in_heater_pwm,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_led_lit,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_last
);

  logic                 align_start;
  logic [TIME_BITS-1:0] align_now;
  align_res_t           align_res;
  q_stat_t              q_stat;
  logic                 push;
  q_entry_t             push_data;
  logic                 pop;
  q_entry_t             head;

  slb_align u_align (
    .clk   (clk),
    .rst_n (rst_n),
    .start (align_start),
    .now   (align_now),
    .res   (align_res)
  );

  slb_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_now_ms         (in_now_ms),
    .in_halt_error     (in_halt_error),
    .in_screen_present (in_screen_present),
    .in_readings_valid (in_readings_valid),
    .in_alerts_pending (in_alerts_pending),
    .in_heater_pwm     (in_heater_pwm),
    .align_start       (align_start),
    .align_now         (align_now),
    .align_res         (align_res),
    .q_stat            (q_stat),
    .push              (push),
    .push_data         (push_data)
  );

  slb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  slb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_led_lit (out_led_lit),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_last    (out_last)
  );

endmodule

@@ tb/tb_status_led_blink_controller_unit.sv @@
`timescale 1ns / 1ps

module tb_status_led_blink_controller_unit;
  import slb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [31:0] now_ms;
    logic        halt;
    logic        screen;
    logic        valid;
    logic        alerts;
    logic [15:0] pwm;
  } tick_t;

  typedef struct {
    logic       lit;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       last;
  } led_t;

  class led_cmd_tracker;
    led_t        pending_cmds[$];
    int          errors;
    bit          aligned;
    logic [31:0] mark_fast;
    logic [31:0] mark_mid;
    logic [31:0] mark_slow;
    bit          ph_fast;
    bit          ph_mid;
    bit          ph_slow;
    mode_t       held_mode;

    function new();
      errors    = 0;
      aligned   = 1'b0;
      mark_fast = '0;
      mark_mid  = '0;
      mark_slow = '0;
      ph_fast   = 1'b0;
      ph_mid    = 1'b0;
      ph_slow   = 1'b0;
      held_mode = MODE_INVALID;
    endfunction

    function bit elapsed(logic [31:0] now, logic [31:0] mark, int span);
      logic [31:0] d;
      d = now - mark;
      return d >= 32'(span);
    endfunction

    function void push_cmd(bit lit, bit r_on, bit g_on, bit b_on);
      led_t c;
      c.lit  = lit;
      c.r    = r_on ? 8'(FULL_LEVEL) : 8'd0;
      c.g    = g_on ? 8'(FULL_LEVEL) : 8'd0;
      c.b    = b_on ? 8'(FULL_LEVEL) : 8'd0;
      c.last = 1'b0;
      pending_cmds.push_back(c);
    endfunction

    function void mark_last(int base);
      if (pending_cmds.size() > base)
        pending_cmds[pending_cmds.size() - 1].last = 1'b1;
    endfunction

    function void note_tick(tick_t tk);
      mode_t m;
      int    base;
      m    = MODE_INVALID;
      base = pending_cmds.size();
      if (!aligned) begin
        aligned   = 1'b1;
        mark_fast = (tk.now_ms / 32'(INT_FAST)) * 32'(INT_FAST);
        mark_mid  = (tk.now_ms / 32'(INT_MID)) * 32'(INT_MID);
        mark_slow = (tk.now_ms / 32'(INT_SLOW)) * 32'(INT_SLOW);
        ph_fast   = 1'b0;
        ph_mid    = 1'b0;
        ph_slow   = 1'b0;
      end
      if (elapsed(tk.now_ms, mark_fast, INT_FAST)) begin
        mark_fast = mark_fast + 32'(INT_FAST);
        if (tk.halt) begin
          if (ph_fast) push_cmd(1'b0, 1'b0, 1'b0, 1'b0);
          else push_cmd(1'b1, 1'b1, 1'b0, 1'b0);
          ph_fast = !ph_fast;
          mark_last(base);
          return;
        end
      end
      if (tk.screen && tk.valid) begin
        if (tk.alerts) begin
          m = MODE_ALERTS;
          if (held_mode != m) push_cmd(1'b1, 1'b1, 1'b0, 1'b0);
        end else if (tk.pwm >= 16'(PWM_THRESHOLD)) begin
          m = MODE_HEATER;
          if (held_mode != m) push_cmd(1'b1, 1'b0, 1'b0, 1'b1);
        end else begin
          m = MODE_ON;
        end
        held_mode = m;
      end
      if (elapsed(tk.now_ms, mark_mid, INT_MID)) begin
        mark_mid = mark_mid + 32'(INT_MID);
        if (m == MODE_ALERTS) begin
          if (ph_mid) push_cmd(1'b0, 1'b0, 1'b0, 1'b0);
          else push_cmd(1'b1, 1'b1, 1'b0, 1'b0);
          ph_mid = !ph_mid;
        end
      end
      if (elapsed(tk.now_ms, mark_slow, INT_SLOW)) begin
        mark_slow = mark_slow + 32'(INT_SLOW);
        if (m == MODE_HEATER) begin
          if (ph_slow) push_cmd(1'b0, 1'b0, 1'b0, 1'b0);
          else push_cmd(1'b1, 1'b0, 1'b0, 1'b1);
          ph_slow = !ph_slow;
        end
      end
      if (m == MODE_ON) push_cmd(1'b1, 1'b0, 1'b1, 1'b0);
      else if (m == MODE_INVALID) push_cmd(1'b1, 1'b1, 1'b1, 1'b1);
      mark_last(base);
    endfunction

    function void cmp_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_cmd(led_t got);
      led_t want;
      if (pending_cmds.size() == 0) begin
        $error("LED command with none expected: lit %0d r %0d g %0d b %0d last %0d",
               got.lit, got.r, got.g, got.b, got.last);
        errors++;
        return;
      end
      want = pending_cmds.pop_front();
      cmp_field("led_lit", want.lit, got.lit);
      cmp_field("red", want.r, got.r);
      cmp_field("green", want.g, got.g);
      cmp_field("blue", want.b, got.b);
      cmp_field("last", want.last, got.last);
    endfunction

    function int pending();
      return pending_cmds.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_now_ms;
  logic        in_halt_error;
  logic        in_screen_present;
  logic        in_readings_valid;
  logic        in_alerts_pending;
  logic [15:0] in_heater_pwm;
  logic        out_valid;
  logic        out_ready;
  logic        out_led_lit;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        out_last;

  led_cmd_tracker tracker;
  int             send_gap_pct;
  int             recv_idle_pct;
  int             recv_hold;
  int             cycles;
  logic [31:0]    t_now;
  bit             sc_alerts;
  bit             sc_heater;
  bit             sc_halt;

  status_led_blink_controller_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_now_ms        (in_now_ms),
    .in_halt_error    (in_halt_error),
    .in_screen_present(in_screen_present),
    .in_readings_valid(in_readings_valid),
    .in_alerts_pending(in_alerts_pending),
    .in_heater_pwm    (in_heater_pwm),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_led_lit      (out_led_lit),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_last         (out_last)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin : monitor
    tick_t tk;
    led_t  got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        tk.now_ms = in_now_ms;
        tk.halt   = in_halt_error;
        tk.screen = in_screen_present;
        tk.valid  = in_readings_valid;
        tk.alerts = in_alerts_pending;
        tk.pwm    = in_heater_pwm;
        tracker.note_tick(tk);
      end
      if (out_valid && out_ready) begin
        got.lit  = out_led_lit;
        got.r    = out_red;
        got.g    = out_green;
        got.b    = out_blue;
        got.last = out_last;
        tracker.check_cmd(got);
      end
    end
  end

  always @(negedge clk) begin
    if (recv_hold > 0) begin
      out_ready <= 1'b0;
      recv_hold--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_tick(tick_t tk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_now_ms         <= tk.now_ms;
    in_halt_error     <= tk.halt;
    in_screen_present <= tk.screen;
    in_readings_valid <= tk.valid;
    in_alerts_pending <= tk.alerts;
    in_heater_pwm     <= tk.pwm;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_fields(logic [31:0] now, bit halt, bit screen, bit valid, bit alerts,
                             logic [15:0] pwm);
    tick_t tk;
    tk.now_ms = now;
    tk.halt   = halt;
    tk.screen = screen;
    tk.valid  = valid;
    tk.alerts = alerts;
    tk.pwm    = pwm;
    t_now     = now;
    send_tick(tk);
  endtask

  // hold the sender off until every LED command has drained
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (tracker.pending() > 0) @(negedge clk);
  endtask

  task automatic run_directed();
    send_fields(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b0, 16'd0);
    send_fields(32'd0,         1'b1, 1'b1, 1'b1, 1'b0, 16'd327);
    send_fields(32'd210,       1'b1, 1'b1, 1'b1, 1'b0, 16'd327);
    send_fields(32'd460,       1'b1, 1'b1, 1'b1, 1'b0, 16'd0);
    send_fields(32'd700,       1'b1, 1'b1, 1'b1, 1'b0, 16'd328);
    send_fields(32'd760,       1'b0, 1'b1, 1'b1, 1'b0, 16'd328);
    send_fields(32'd800,       1'b0, 1'b1, 1'b1, 1'b1, 16'd0);
    send_fields(32'd1300,      1'b0, 1'b1, 1'b1, 1'b1, 16'd0);
    send_fields(32'd1350,      1'b0, 1'b0, 1'b1, 1'b1, 16'd0);
    send_fields(32'd1400,      1'b0, 1'b1, 1'b0, 1'b1, 16'd0);
    send_fields(32'd1450,      1'b0, 1'b1, 1'b1, 1'b1, 16'd0);
    send_fields(32'd2000,      1'b0, 1'b1, 1'b1, 1'b0, 16'hFFFF);
    send_fields(32'd2500,      1'b0, 1'b1, 1'b1, 1'b0, 16'hFFFF);
    send_fields(32'd3000,      1'b0, 1'b1, 1'b1, 1'b0, 16'd328);
    send_fields(32'd4500,      1'b0, 1'b1, 1'b1, 1'b0, 16'd40000);
    send_fields(32'd6500,      1'b0, 1'b1, 1'b1, 1'b0, 16'd40000);
    send_fields(32'd6550,      1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
    send_fields(32'd6800,      1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF);
    send_fields(32'd6900,      1'b0, 1'b1, 1'b1, 1'b0, 16'd100);
    send_fields(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b1, 16'd0);
    send_fields(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b1, 16'd0);
    send_fields(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b0, 16'd500);
  endtask

  task automatic run_random(int count);
    tick_t tk;
    int    r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 85) t_now = t_now + 32'd50;
      else if (r < 93) t_now = t_now + $urandom_range(600);
      else if (r < 96) t_now = $urandom;
      else if (r < 98) t_now = 32'hFFFF_FFFF - $urandom_range(3000);
      if ($urandom_range(99) < 6) sc_alerts = !sc_alerts;
      if ($urandom_range(99) < 6) sc_heater = !sc_heater;
      if ($urandom_range(99) < 4) sc_halt = !sc_halt;
      tk.now_ms = t_now;
      tk.halt   = sc_halt;
      tk.screen = ($urandom_range(99) >= 8);
      tk.valid  = ($urandom_range(99) >= 8);
      tk.alerts = sc_alerts;
      if ($urandom_range(9) == 0)
        tk.pwm = sc_heater ? 16'(PWM_THRESHOLD) : 16'(PWM_THRESHOLD - 1);
      else if (sc_heater)
        tk.pwm = 16'($urandom_range(65535, PWM_THRESHOLD));
      else
        tk.pwm = 16'($urandom_range(PWM_THRESHOLD - 1, 0));
      send_tick(tk);
    end
  endtask

  initial begin
    tracker           = new();
    cycles            = 0;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_now_ms         = '0;
    in_halt_error     = 1'b0;
    in_screen_present = 1'b0;
    in_readings_valid = 1'b0;
    in_alerts_pending = 1'b0;
    in_heater_pwm     = '0;
    out_ready         = 1'b0;
    send_gap_pct      = 0;
    recv_idle_pct     = 0;
    recv_hold         = 0;
    t_now             = '0;
    sc_alerts         = 1'b0;
    sc_heater         = 1'b0;
    sc_halt           = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    drain();

    send_gap_pct  = 22;
    recv_idle_pct = 80;
    run_random(200);
    drain();

    send_gap_pct  = 80;
    recv_idle_pct = 22;
    run_random(200);
    drain();

    send_gap_pct  = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    recv_hold = 120;
    @(negedge clk);
    run_random(200);
    drain();

    repeat (40) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/slb_pkg.sv
rtl/slb_align.sv
rtl/slb_front.sv
rtl/slb_queue.sv
rtl/slb_back.sv
rtl/status_led_blink_controller_unit.sv
tb/tb_status_led_blink_controller_unit.sv
